>>> hw/rtl/lts_pkg.sv
// ----------------------------------------------------------------------------
// lts_pkg
// Shared types, constants and keyword lookup for the Lisp token scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package lts_pkg;

    localparam int MAX_WORD_CHARS = 8;
    localparam int NUMBER_BITS    = 31;
    localparam int LINE_BITS      = 20;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [NUMBER_BITS-1:0] NUM_MAX  = {NUMBER_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};

    typedef logic [4:0] t_kind;

    localparam t_kind K_END    = 5'd0;
    localparam t_kind K_LPAREN = 5'd1;
    localparam t_kind K_RPAREN = 5'd2;
    localparam t_kind K_ADD    = 5'd3;
    localparam t_kind K_SUB    = 5'd4;
    localparam t_kind K_DIV    = 5'd5;
    localparam t_kind K_MUL    = 5'd6;
    localparam t_kind K_QUOTE  = 5'd7;
    localparam t_kind K_NUMBER = 5'd8;
    localparam t_kind K_WORD   = 5'd9;
    localparam t_kind K_ERROR  = 5'd10;
    localparam t_kind K_LAMBDA = 5'd11;
    localparam t_kind K_LET    = 5'd12;
    localparam t_kind K_DEFINE = 5'd13;
    localparam t_kind K_COND   = 5'd14;
    localparam t_kind K_TRUE   = 5'd15;
    localparam t_kind K_FALSE  = 5'd16;
    localparam t_kind K_LIST   = 5'd17;
    localparam t_kind K_CONS   = 5'd18;
    localparam t_kind K_CDR    = 5'd19;
    localparam t_kind K_CAR    = 5'd20;
    localparam t_kind K_EQ     = 5'd21;
    localparam t_kind K_NULL   = 5'd22;
    localparam t_kind K_MODULO = 5'd23;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_TICK   = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_QMARK  = 8'h3F;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_NUM  = 2'd1,
        MODE_WORD = 2'd2
    } t_mode;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_input;
    } t_item;

    typedef struct packed {
        t_kind                  token_kind;
        logic [NUMBER_BITS-1:0] number_value;
        logic [63:0]            word_text;
        logic [3:0]             word_length;
        logic                   overflow_flag;
        logic [LINE_BITS-1:0]   line_number;
        logic                   last_of_run;
    } t_result;

    // results produced by one input transaction, first in res0
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

    function automatic t_result simple_token(t_kind kind, logic [LINE_BITS-1:0] line);
        t_result r;
        r               = '0;
        r.token_kind    = kind;
        r.line_number   = line;
        return r;
    endfunction

    // word text is packed first char low, so the literals are written reversed
    function automatic t_kind keyword_kind(logic [63:0] text, logic [3:0] len, logic ovf);
        t_kind k;
        k = K_WORD;
        if (!ovf) begin
            if      (len == 4'd6 && text == 64'("adbmal")) k = K_LAMBDA;
            else if (len == 4'd3 && text == 64'("tel"))    k = K_LET;
            else if (len == 4'd6 && text == 64'("enifed")) k = K_DEFINE;
            else if (len == 4'd4 && text == 64'("dnoc"))   k = K_COND;
            else if (len == 4'd2 && text == 64'("t#"))     k = K_TRUE;
            else if (len == 4'd2 && text == 64'("f#"))     k = K_FALSE;
            else if (len == 4'd4 && text == 64'("tsil"))   k = K_LIST;
            else if (len == 4'd4 && text == 64'("snoc"))   k = K_CONS;
            else if (len == 4'd3 && text == 64'("rdc"))    k = K_CDR;
            else if (len == 4'd3 && text == 64'("rac"))    k = K_CAR;
            else if (len == 4'd3 && text == 64'("?qe"))    k = K_EQ;
            else if (len == 4'd5 && text == 64'("?llun"))  k = K_NULL;
            else if (len == 4'd5 && text == 64'("etouq"))  k = K_QUOTE;
            else if (len == 4'd6 && text == 64'("oludom")) k = K_MODULO;
        end
        return k;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lts_core.sv
// ----------------------------------------------------------------------------
// lts_core
// Scanner state and the per-character step: yields up to two tokens.
// ----------------------------------------------------------------------------
`default_nettype none

module lts_core (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_take,
    input  lts_pkg::t_item i_item,
    output lts_pkg::t_push o_push
);
    import lts_pkg::*;

    localparam int ACC_W = NUMBER_BITS + 4;

    t_mode                  r_mode, n_mode;
    logic [NUMBER_BITS-1:0] r_acc, n_acc;
    logic [63:0]            r_buf, n_buf;
    logic [3:0]             r_wcnt, n_wcnt;
    logic                   r_ovf, n_ovf;
    logic [LINE_BITS-1:0]   r_line, n_line;

    logic [7:0]       c;
    logic             eoi, is_digit, is_alpha, word_char, word_start, blank;
    logic [ACC_W-1:0] acc_next;
    logic             acc_sat;
    logic             word_room;

    assign c          = i_item.char_byte;
    assign eoi        = i_item.end_of_input;
    assign is_digit   = (c >= 8'h30) && (c <= 8'h39);
    assign is_alpha   = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    assign word_char  = is_alpha || is_digit || (c == CH_QMARK);
    assign word_start = is_alpha || (c == CH_HASH);
    assign blank      = (c == CH_SPACE) || (c == CH_TAB);

    // acc*10 + digit, compared against the saturation limit
    assign acc_next  = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + ACC_W'(c[3:0]);
    assign acc_sat   = acc_next > ACC_W'(NUM_MAX);
    assign word_room = (r_wcnt < 4'(MAX_WORD_CHARS)) && (r_wcnt < 4'd8);

    // next state
    always_comb begin
        n_mode = r_mode;
        n_acc  = r_acc;
        n_buf  = r_buf;
        n_wcnt = r_wcnt;
        n_ovf  = r_ovf;
        n_line = r_line;
        if (eoi) begin
            n_mode = MODE_IDLE;
        end else if (r_mode == MODE_NUM && is_digit) begin
            if (acc_sat) begin
                n_acc = NUM_MAX;
                n_ovf = 1'b1;
            end else begin
                n_acc = acc_next[NUMBER_BITS-1:0];
            end
        end else if (r_mode == MODE_WORD && word_char) begin
            if (word_room) begin
                n_buf  = r_buf | (64'(c) << {r_wcnt[2:0], 3'b000});
                n_wcnt = r_wcnt + 4'd1;
            end else begin
                n_ovf = 1'b1;
            end
        end else begin
            n_mode = MODE_IDLE;
            if (c == CH_NL) begin
                if (r_line != LINE_MAX) n_line = r_line + LINE_BITS'(1);
            end else if (is_digit) begin
                n_mode = MODE_NUM;
                n_acc  = NUMBER_BITS'(c[3:0]);
                n_ovf  = 1'b0;
            end else if (word_start) begin
                n_mode = MODE_WORD;
                n_buf  = 64'(c);
                n_wcnt = 4'd1;
                n_ovf  = 1'b0;
            end
        end
    end

    // outputs
    t_result flush_res, tok_res;
    logic    have_flush, have_tok;
    t_kind   kw, tok_kind;

    always_comb begin
        kw        = keyword_kind(r_buf, r_wcnt, r_ovf);
        flush_res = simple_token(K_NUMBER, r_line);
        have_flush = 1'b0;
        case (r_mode)
            MODE_NUM: begin
                have_flush                = 1'b1;
                flush_res.number_value    = r_acc;
                flush_res.overflow_flag   = r_ovf;
            end
            MODE_WORD: begin
                have_flush = 1'b1;
                if (kw == K_WORD) begin
                    flush_res.token_kind    = K_WORD;
                    flush_res.word_text     = r_buf;
                    flush_res.word_length   = r_wcnt;
                    flush_res.overflow_flag = r_ovf;
                end else begin
                    flush_res.token_kind = kw;
                end
            end
            default: have_flush = 1'b0;
        endcase

        case (c)
            CH_LPAREN: tok_kind = K_LPAREN;
            CH_RPAREN: tok_kind = K_RPAREN;
            CH_PLUS:   tok_kind = K_ADD;
            CH_MINUS:  tok_kind = K_SUB;
            CH_SLASH:  tok_kind = K_DIV;
            CH_STAR:   tok_kind = K_MUL;
            CH_TICK:   tok_kind = K_QUOTE;
            default:   tok_kind = K_ERROR;
        endcase
        have_tok = !(blank || c == CH_NL || is_digit || word_start);

        if (eoi) begin
            tok_res  = simple_token(K_END, r_line);
            have_tok = 1'b1;
        end else begin
            tok_res = simple_token(tok_kind, r_line);
            if ((r_mode == MODE_NUM && is_digit) || (r_mode == MODE_WORD && word_char)) begin
                have_flush = 1'b0;
                have_tok   = 1'b0;
            end
        end
        tok_res.last_of_run = 1'b1;

        o_push = '0;
        if (i_take) begin
            if (have_flush) begin
                o_push.res0 = flush_res;
                o_push.res1 = tok_res;
                if (have_tok) begin
                    o_push.count = 2'd2;
                end else begin
                    o_push.count            = 2'd1;
                    o_push.res0.last_of_run = 1'b1;
                end
            end else begin
                o_push.res0  = tok_res;
                o_push.res1  = tok_res;
                o_push.count = {1'b0, have_tok};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_acc  <= '0;
            r_buf  <= '0;
            r_wcnt <= '0;
            r_ovf  <= 1'b0;
            r_line <= '0;
        end else if (i_take) begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_buf  <= n_buf;
            r_wcnt <= n_wcnt;
            r_ovf  <= n_ovf;
            r_line <= n_line;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/lts_out_queue.sv
// ----------------------------------------------------------------------------
// lts_out_queue
// Shifting result queue: takes up to two tokens a cycle, hands out one while not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module lts_out_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  lts_pkg::t_push   i_push,
    input  wire              i_stall,
    output logic             o_valid,
    output lts_pkg::t_result o_res,
    output logic             o_full
);
    import lts_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_result         r_slot [QUEUE_DEPTH];
    t_result         n_slot [QUEUE_DEPTH];
    logic [CW-1:0]   r_cnt, n_cnt, base;
    logic            pop;

    assign o_valid = (r_cnt != '0);
    assign o_res   = r_slot[0];
    assign pop     = o_valid && !i_stall;
    // room for two more must be certain before a transaction is taken
    assign o_full  = r_cnt > CW'(QUEUE_DEPTH - 2);
    assign base    = r_cnt - CW'(pop);
    assign n_cnt   = base + CW'(i_push.count);

    always_comb begin
        for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
            n_slot[j] = pop ? r_slot[j + 1] : r_slot[j];
        end
        n_slot[QUEUE_DEPTH-1] = r_slot[QUEUE_DEPTH-1];
        for (int j = 0; j < QUEUE_DEPTH; j++) begin
            if (i_push.count != 2'd0 && base == CW'(j)) begin
                n_slot[j] = i_push.res0;
            end else if (i_push.count == 2'd2 && base + CW'(1) == CW'(j)) begin
                n_slot[j] = i_push.res1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cnt <= '0;
        else          r_cnt <= n_cnt;
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < QUEUE_DEPTH; j++) r_slot[j] <= n_slot[j];
    end

endmodule

`default_nettype wire

>>> hw/rtl/lisp_token_scanner.sv
// ----------------------------------------------------------------------------
// lisp_token_scanner
// Tokenizer for a small Lisp-like text, one character byte per transaction.
// ----------------------------------------------------------------------------
// Output: with the queue empty, the first token of a transaction is offered
// in the cycle after it is taken; a second token follows once the first is popped.
// Throughput: one character per cycle; each input yields zero to two tokens and
// the four-entry result queue stalls input while it holds three or more.
// Reset: synchronous, active low; clears scan mode, accumulators, line count
// and the queue.
`default_nettype none

module lisp_token_scanner (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_stall,
    input  lts_pkg::t_item   i_item,
    output logic             o_valid,
    input  wire              i_stall,
    output lts_pkg::t_result o_res
);
    import lts_pkg::*;

    t_push push;
    logic  full;
    logic  take;

    assign o_stall = full;
    assign take    = i_valid && !full;

    lts_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_item  (i_item),
        .o_push  (push)
    );

    lts_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_res   (o_res),
        .o_full  (full)
    );

endmodule

`default_nettype wire
